### rtl/core/tlik_pkg.sv
// Shared constants, types and helpers for the two-link arm inverse kinematics unit.
// Used by tlik_cordic and the top level; depends on nothing.
package tlik_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int LEN_FRAC            = 16;
    localparam int TABLE_FRAC          = 24;
    localparam int TABLE_LEN           = 28;
    localparam int CORDIC_W            = 34;

    // floor square root of (value << 32): 60-bit radicand, 30-bit root, one bit a stage
    localparam int RAD_W    = 60;
    localparam int ROOT_W   = 30;
    localparam int REM_W    = 32;
    localparam int SQ_STEPS = 30;

    localparam logic [11:0] LINK_LEN_RESET = 12'd1778;

    typedef enum logic [0:0] {
        REG_LINK_LEN = 1'b0
    } reg_idx_t;

    // atan(2^-i) in degrees, 24 fraction bits
    localparam logic [29:0] ATAN_Q24 [0:TABLE_LEN-1] = '{
        30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
        30'd30029717, 30'd15018523, 30'd7509720, 30'd3754917, 30'd1877466,
        30'd938734, 30'd469367, 30'd234683, 30'd117342, 30'd58671, 30'd29335,
        30'd14668, 30'd7334, 30'd3667, 30'd1834, 30'd917, 30'd458, 30'd229,
        30'd115, 30'd57, 30'd29, 30'd14, 30'd7
    };

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_t;

    // one digit of a restoring square root
    function automatic sq_t sqrt_step(sq_t cur, logic [1:0] two);
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        sq_t              res;
        rem_sh = {cur.rem[REM_W-3:0], two};
        trial  = {cur.root, 2'b01};
        if (rem_sh >= trial) begin
            res.rem  = rem_sh - trial;
            res.root = {cur.root[ROOT_W-2:0], 1'b1};
        end else begin
            res.rem  = rem_sh;
            res.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

### rtl/core/tlik_cordic.sv
// Pipelined CORDIC vectoring unit: atan2(b, a) in degrees for a >= 0.
// Depends on tlik_pkg for the arctangent table and data widths.
module tlik_cordic #(
    parameter int AFB = tlik_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic signed [tlik_pkg::CORDIC_W-1:0]   a_in,
    input  logic signed [tlik_pkg::CORDIC_W-1:0]   b_in,
    output logic signed [AFB+9:0]                  angle_out
);
    import tlik_pkg::*;

    localparam int ITER = AFB + 2;
    localparam int AW   = AFB + 10;
    localparam logic signed [AW-1:0] RIGHT = AW'(90 << AFB);

    logic signed [CORDIC_W-1:0] a_reg    [0:ITER-1];
    logic signed [CORDIC_W-1:0] b_reg    [0:ITER-1];
    logic signed [AW-1:0]       acc_reg  [0:ITER-1];
    logic                       spec_reg [0:ITER-1];
    logic signed [AW-1:0]       sval_reg [0:ITER-1];

    for (genvar i = 0; i < ITER; i++) begin : g_iter
        localparam logic [AW-1:0] STEP = AW'(ATAN_Q24[i] >> (TABLE_FRAC - AFB));
        logic signed [CORDIC_W-1:0] a_p;
        logic signed [CORDIC_W-1:0] b_p;
        logic signed [AW-1:0]       acc_p;
        logic                       spec_p;
        logic signed [AW-1:0]       sval_p;

        if (i == 0) begin : g_first
            assign a_p    = a_in;
            assign b_p    = b_in;
            assign acc_p  = '0;
            // no usable a: the angle is straight up, straight down or zero
            assign spec_p = (a_in <= 0);
            assign sval_p = (b_in > 0) ? RIGHT : ((b_in < 0) ? -RIGHT : '0);
        end else begin : g_rest
            assign a_p    = a_reg[i-1];
            assign b_p    = b_reg[i-1];
            assign acc_p  = acc_reg[i-1];
            assign spec_p = spec_reg[i-1];
            assign sval_p = sval_reg[i-1];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!b_p[CORDIC_W-1]) begin
                    a_reg[i]   <= a_p + (b_p >>> i);
                    b_reg[i]   <= b_p - (a_p >>> i);
                    acc_reg[i] <= acc_p + $signed(STEP);
                end else begin
                    a_reg[i]   <= a_p - (b_p >>> i);
                    b_reg[i]   <= b_p + (a_p >>> i);
                    acc_reg[i] <= acc_p - $signed(STEP);
                end
                spec_reg[i] <= spec_p;
                sval_reg[i] <= sval_p;
            end
        end
    end

    assign angle_out = spec_reg[ITER-1] ? sval_reg[ITER-1] : acc_reg[ITER-1];

endmodule

### rtl/core/two_link_arm_inverse_kinematics_unit.sv
// Top level of the two-link arm inverse kinematics unit.
// Depends on tlik_pkg and tlik_cordic.
//
// Usage:
//   s_ channel carries one target point per request: s_tdata holds x, y, z (11-bit signed mm).
//   m_ channel returns base, shoulder and elbow angles in whole degrees; m_tuser flags
//   whether the point is within reach. Unreachable points give zero shoulder and elbow.
//   The link length is set through the APB port (register 0, tenths of a mm); write it
//   only while no request is in flight.
// Pipeline: input register, squares, distances, 30 square-root digit stages,
//   ANGLE_FRAC_BITS+2 CORDIC stages, output register.
// Throughput: one request per cycle while m_tready does not hold the pipeline; every
//   stage is a register level of the pipeline.
// Reset clears all valid bits and loads the default link length (177.8 mm).
// When m_tready is low with a result waiting, the whole pipeline holds and s_tready
// drops; nothing is lost or repeated.
module two_link_arm_inverse_kinematics_unit #(
    parameter int ANGLE_FRAC_BITS = tlik_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // target_x[10:0], target_y[21:11], target_z[32:22]
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // base[7:0], shoulder[16:8], elbow[25:17]
    output logic        m_tuser    // reachable
);
    import tlik_pkg::*;

    localparam int AFB  = ANGLE_FRAC_BITS;
    localparam int ITER = AFB + 2;
    localparam int AW   = AFB + 10;

    logic ce;

    // configuration
    logic [11:0] link_len_reg;
    logic        cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = (reg_idx_t'(paddr[2]) == REG_LINK_LEN);
    assign prdata  = cfg_sel ? {20'd0, link_len_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_len_reg <= LINK_LEN_RESET;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            link_len_reg <= pwdata[11:0];
        end
    end

    // stage 0: input register
    logic               v0_reg;
    logic signed [10:0] x0_reg, y0_reg, z0_reg;
    logic [11:0]        l0_reg;

    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (ce) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            x0_reg <= s_tdata[10:0];
            y0_reg <= s_tdata[21:11];
            z0_reg <= s_tdata[32:22];
            l0_reg <= link_len_reg;
        end
    end

    // stage 1: squares
    logic               v1_reg;
    logic signed [10:0] x1_reg, y1_reg, z1_reg;
    logic [20:0]        xx1_reg, yy1_reg, zz1_reg;
    logic [23:0]        ll1_reg;
    logic signed [21:0] xx_full, yy_full, zz_full;

    assign xx_full = x0_reg * x0_reg;
    assign yy_full = y0_reg * y0_reg;
    assign zz_full = z0_reg * z0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            x1_reg  <= x0_reg;
            y1_reg  <= y0_reg;
            z1_reg  <= z0_reg;
            xx1_reg <= xx_full[20:0];
            yy1_reg <= yy_full[20:0];
            zz1_reg <= zz_full[20:0];
            ll1_reg <= l0_reg * l0_reg;
        end
    end

    // stage 2: distances and reach test
    logic               v2_reg;
    logic signed [10:0] x2_reg, y2_reg, z2_reg;
    logic [21:0]        r2_reg;
    logic [26:0]        d2t_reg;
    logic [26:0]        opp2_reg;
    logic               reach2_reg;
    logic [21:0]        r2_next;
    logic [21:0]        d2_next;
    logic [28:0]        d2t_next;
    logic [25:0]        span2_next;
    logic [28:0]        opp_diff;

    assign r2_next    = 22'(xx1_reg) + 22'(yy1_reg);
    assign d2_next    = r2_next + 22'(zz1_reg);
    assign d2t_next   = 29'(d2_next) * 29'd100;
    assign span2_next = {ll1_reg, 2'b00};
    assign opp_diff   = 29'(span2_next) - d2t_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ce) begin
            v2_reg <= v1_reg;
        end
    end

    // unreachable points keep whatever lands in the low bits; their shoulder and elbow angles are dropped
    always_ff @(posedge aclk) begin
        if (ce) begin
            x2_reg     <= x1_reg;
            y2_reg     <= y1_reg;
            z2_reg     <= z1_reg;
            r2_reg     <= r2_next;
            d2t_reg    <= d2t_next[26:0];
            opp2_reg   <= opp_diff[26:0];
            reach2_reg <= (d2t_next <= 29'(span2_next));
        end
    end

    // square-root digit stages, three lanes: r, adjacent, opposite
    logic [RAD_W-1:0]   rad_reg   [0:2][0:SQ_STEPS-1];
    sq_t                sq_reg    [0:2][0:SQ_STEPS-1];
    logic               vs_reg    [0:SQ_STEPS-1];
    logic signed [10:0] xs_reg    [0:SQ_STEPS-1];
    logic signed [10:0] ys_reg    [0:SQ_STEPS-1];
    logic signed [10:0] zs_reg    [0:SQ_STEPS-1];
    logic               reachs_reg[0:SQ_STEPS-1];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        logic [RAD_W-1:0]   rad_p [0:2];
        sq_t                sq_p  [0:2];
        logic               v_p;
        logic signed [10:0] x_p, y_p, z_p;
        logic               reach_p;

        if (k == 0) begin : g_first
            assign rad_p[0] = {6'd0, r2_reg, 32'd0};
            assign rad_p[1] = {1'b0, d2t_reg, 32'd0};
            assign rad_p[2] = {1'b0, opp2_reg, 32'd0};
            assign sq_p[0]  = '0;
            assign sq_p[1]  = '0;
            assign sq_p[2]  = '0;
            assign v_p      = v2_reg;
            assign x_p      = x2_reg;
            assign y_p      = y2_reg;
            assign z_p      = z2_reg;
            assign reach_p  = reach2_reg;
        end else begin : g_rest
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign rad_p[l] = rad_reg[l][k-1];
                assign sq_p[l]  = sq_reg[l][k-1];
            end
            assign v_p     = vs_reg[k-1];
            assign x_p     = xs_reg[k-1];
            assign y_p     = ys_reg[k-1];
            assign z_p     = zs_reg[k-1];
            assign reach_p = reachs_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vs_reg[k] <= 1'b0;
            end else if (ce) begin
                vs_reg[k] <= v_p;
            end
        end

        for (genvar l = 0; l < 3; l++) begin : g_step
            always_ff @(posedge aclk) begin
                if (ce) begin
                    rad_reg[l][k] <= {rad_p[l][RAD_W-3:0], 2'b00};
                    sq_reg[l][k]  <= sqrt_step(sq_p[l], rad_p[l][RAD_W-1:RAD_W-2]);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                xs_reg[k]     <= x_p;
                ys_reg[k]     <= y_p;
                zs_reg[k]     <= z_p;
                reachs_reg[k] <= reach_p;
            end
        end
    end

    // CORDIC inputs
    logic signed [10:0]         xq, yq, zq;
    logic [10:0]                ax, ay;
    logic signed [CORDIC_W-1:0] base_a, base_b, phi_a, phi_b, th_a, th_b;
    logic signed [7:0]          base_sp;
    logic                       base_flip;

    assign xq = xs_reg[SQ_STEPS-1];
    assign yq = ys_reg[SQ_STEPS-1];
    assign zq = zs_reg[SQ_STEPS-1];
    assign ax = xq[10] ? 11'(-xq) : 11'(xq);
    assign ay = yq[10] ? 11'(-yq) : 11'(yq);

    assign base_a = $signed({{(CORDIC_W-11-LEN_FRAC){1'b0}}, ax, {LEN_FRAC{1'b0}}});
    assign base_b = $signed({{(CORDIC_W-11-LEN_FRAC){1'b0}}, ay, {LEN_FRAC{1'b0}}});
    assign phi_a  = $signed({{(CORDIC_W-ROOT_W){1'b0}}, sq_reg[0][SQ_STEPS-1].root});
    assign phi_b  = $signed({{(CORDIC_W-11-LEN_FRAC){zq[10]}}, zq, {LEN_FRAC{1'b0}}});
    assign th_a   = $signed({{(CORDIC_W-ROOT_W){1'b0}}, sq_reg[1][SQ_STEPS-1].root});
    assign th_b   = $signed({{(CORDIC_W-ROOT_W){1'b0}}, sq_reg[2][SQ_STEPS-1].root});

    // x on the axis: base points straight along +y, -y or nowhere
    assign base_sp   = (yq > 0) ? 8'sd90 : ((yq < 0) ? -8'sd90 : 8'sd0);
    assign base_flip = (xq[10] != yq[10]);

    logic signed [AW-1:0] base_ang, phi_ang, th_ang;

    tlik_cordic #(.AFB(AFB)) u_base (
        .aclk(aclk), .en(ce), .a_in(base_a), .b_in(base_b), .angle_out(base_ang)
    );
    tlik_cordic #(.AFB(AFB)) u_phi (
        .aclk(aclk), .en(ce), .a_in(phi_a), .b_in(phi_b), .angle_out(phi_ang)
    );
    tlik_cordic #(.AFB(AFB)) u_theta (
        .aclk(aclk), .en(ce), .a_in(th_a), .b_in(th_b), .angle_out(th_ang)
    );

    // side data alongside the CORDIC stages
    logic              vc_reg     [0:ITER-1];
    logic              xz_reg     [0:ITER-1];
    logic              flip_reg   [0:ITER-1];
    logic signed [7:0] sp_reg     [0:ITER-1];
    logic              reachc_reg [0:ITER-1];

    for (genvar i = 0; i < ITER; i++) begin : g_side
        logic              v_p, xz_p, flip_p, reach_p;
        logic signed [7:0] sp_p;

        if (i == 0) begin : g_first
            assign v_p     = vs_reg[SQ_STEPS-1];
            assign xz_p    = (xq == 11'sd0);
            assign flip_p  = base_flip;
            assign sp_p    = base_sp;
            assign reach_p = reachs_reg[SQ_STEPS-1];
        end else begin : g_rest
            assign v_p     = vc_reg[i-1];
            assign xz_p    = xz_reg[i-1];
            assign flip_p  = flip_reg[i-1];
            assign sp_p    = sp_reg[i-1];
            assign reach_p = reachc_reg[i-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vc_reg[i] <= 1'b0;
            end else if (ce) begin
                vc_reg[i] <= v_p;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                xz_reg[i]     <= xz_p;
                flip_reg[i]   <= flip_p;
                sp_reg[i]     <= sp_p;
                reachc_reg[i] <= reach_p;
            end
        end
    end

    // output stage: combine and truncate toward zero
    localparam logic signed [AW:0] STRAIGHT = (AW+1)'(longint'(180) << AFB);

    logic signed [AW:0] sh_fx, el_fx;
    logic [AW:0]        sh_mag, el_mag, b_mag;
    logic [AW:0]        sh_q, el_q, b_q;
    logic [8:0]         shoulder_v, elbow_v;
    logic [7:0]         base_v;
    logic               reach_o;

    assign sh_fx  = STRAIGHT - {phi_ang[AW-1], phi_ang} + {th_ang[AW-1], th_ang};
    assign el_fx  = {phi_ang[AW-1], phi_ang} + {th_ang[AW-1], th_ang};
    assign sh_mag = sh_fx[AW] ? (AW+1)'(-sh_fx) : (AW+1)'(sh_fx);
    assign el_mag = el_fx[AW] ? (AW+1)'(-el_fx) : (AW+1)'(el_fx);
    assign b_mag  = base_ang[AW-1] ? (AW+1)'(-{base_ang[AW-1], base_ang})
                                   : (AW+1)'({base_ang[AW-1], base_ang});
    assign sh_q   = sh_fx[AW] ? (AW+1)'(-(sh_mag >> AFB)) : (sh_mag >> AFB);
    assign el_q   = el_fx[AW] ? (AW+1)'(-(el_mag >> AFB)) : (el_mag >> AFB);
    assign b_q    = (base_ang[AW-1] != flip_reg[ITER-1]) ? (AW+1)'(-(b_mag >> AFB))
                                                          : (b_mag >> AFB);

    assign reach_o    = reachc_reg[ITER-1];
    assign shoulder_v = reach_o ? sh_q[8:0] : 9'd0;
    assign elbow_v    = reach_o ? el_q[8:0] : 9'd0;
    assign base_v     = xz_reg[ITER-1] ? sp_reg[ITER-1] : b_q[7:0];

    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic        m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            m_tvalid_reg <= vc_reg[ITER-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_tdata_reg <= {6'd0, elbow_v, shoulder_v, base_v};
            m_tuser_reg <= reach_o;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
